@@ hdl/phct_pkg.sv @@
// Shared constants and codes for the perfect-hash character translation block.
package phct_pkg;

  // Default sizes of the stores and of one character.
  localparam int MAX_TABLE_DEF = 256;
  localparam int MAX_PAIRS_DEF = 255;
  localparam int CHAR_BITS_DEF = 16;

  // Width of the multiplier and search limit, fixed by the register map.
  localparam int MULT_BITS = 8;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_LOAD      = 2'd0,
    REQ_BUILD     = 2'd1,
    REQ_TRANSLATE = 2'd2,
    REQ_CLEAR     = 2'd3
  } req_t;

  // Status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOHASH = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Configuration register indexes.
  localparam logic CFG_SEARCH_LIMIT = 1'b0;
  localparam logic CFG_COMPRESS     = 1'b1;

endpackage

@@ hdl/perfect_hash_char_translate.sv @@
// Top level of the perfect-hash character translation table.
//
//  channel  direction  handshake                     payload
//  req      in         req_valid / req_stall         req_type, key, value
//  rsp      out        rsp_valid / rsp_stall         status, result_char, member,
//                                                    table_size, multiplier
//  cfg      in         wr_en (no wait)               wr_index, wr_data
//
// Load and clear go straight to the output stage, as does a translate with no
// built table or key zero. A translate of a built table passes through the
// remainder unit, the registered table read, the compare and the output stage.
// A build trial runs each kept pair it places through the remainder unit and a slot
// check, each pair walked back after a collision through the remainder unit alone,
// and skips an identity pair; success adds a sweep that clears the spare table bank.
// After reset the spare bank is cleared in the same sweep; no beat is taken then.
// One beat is worked on at a time; a finished result waits in the output register.
module perfect_hash_char_translate
  import phct_pkg::*;
#(
  parameter int MAX_TABLE = MAX_TABLE_DEF,
  parameter int MAX_PAIRS = MAX_PAIRS_DEF,
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           req_type,
  input  logic [CHAR_BITS-1:0] key,
  input  logic [CHAR_BITS-1:0] value,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [1:0]           status,
  output logic [CHAR_BITS-1:0] result_char,
  output logic                 member,
  output logic [7:0]           table_size,
  output logic [7:0]           multiplier,
  input  logic                 wr_en,
  input  logic                 wr_index,
  input  logic [7:0]           wr_data
);

  localparam int SW  = $clog2(MAX_TABLE);
  localparam int PW  = $clog2(MAX_PAIRS + 1);
  localparam int PIW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int P   = CHAR_BITS + MULT_BITS;
  localparam int AW  = SW + 1;
  localparam int CB  = CHAR_BITS;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_T_MOD, S_T_CMP, S_B_LOOP, S_B_PREAD, S_B_MOD,
    S_B_CHECK, S_B_NEXT, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [7:0] search_limit;
  logic       compress;

  // Table state.
  logic [PW-1:0]        pair_count;
  logic [SW-1:0]        chosen_size;
  logic [MULT_BITS-1:0] chosen_mult;
  logic                 built;
  logic                 live_bank;

  // Build walk.
  logic [SW-1:0]        size_r;
  logic [MULT_BITS-1:0] mult_r;
  logic [PW-1:0]        j;
  logic [PW-1:0]        fail_j;
  logic                 undo;
  logic [SW-1:0]        sweep_idx;
  logic                 post_build;
  logic [CB-1:0]        k_r;
  logic [CB-1:0]        v_r;
  logic [SW-1:0]        slot_r;

  // Pending result.
  status_t       st_r;
  logic [CB-1:0] ch_r;
  logic          mem_r;

  // Pair memory.
  logic [CB-1:0]  pk_mem [MAX_PAIRS];
  logic [CB-1:0]  pv_mem [MAX_PAIRS];
  logic           pm_we;
  logic [PIW-1:0] pm_waddr;
  logic [PIW-1:0] pm_raddr;
  logic [CB-1:0]  pk_q;
  logic [CB-1:0]  pv_q;

  // Table memory: two banks, one live and one used as scratch during a build.
  logic [CB-1:0] tk_mem [2**AW];
  logic [CB-1:0] tv_mem [2**AW];
  logic          tm_we;
  logic [AW-1:0] tm_addr;
  logic [CB-1:0] tm_wk;
  logic [CB-1:0] tm_wv;
  logic [CB-1:0] tk_q;
  logic [CB-1:0] tv_q;

  // Remainder unit.
  logic          md_start;
  logic [P-1:0]  md_dividend;
  logic [SW-1:0] md_divisor;
  logic          md_done;
  logic [SW-1:0] md_rem;

  logic req_acc;
  logic skip_pair;
  logic slot_free;

  assign req_acc   = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign skip_pair = compress && (pk_q == pv_q);
  assign slot_free = (tk_q == '0) || (tk_q == k_r);
  assign pm_raddr  = j[PIW-1:0];
  assign pm_waddr  = pair_count[PIW-1:0];
  assign pm_we     = req_acc && (req_type == REQ_LOAD) && (key != '0)
                     && (pair_count < PW'(MAX_PAIRS));

  phct_mod #(.P(P), .SW(SW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (md_start),
    .dividend (md_dividend),
    .divisor  (md_divisor),
    .done     (md_done),
    .rem      (md_rem)
  );

  // Remainder requests: the table lookup of a translate, or a pair during a build.
  always_comb begin
    md_start    = 1'b0;
    md_dividend = P'(key) * P'(chosen_mult);
    md_divisor  = chosen_size;
    if (state == S_B_PREAD) begin
      md_start    = !skip_pair;
      md_dividend = P'(pk_q) * P'(mult_r);
      md_divisor  = size_r;
    end else if (req_acc && (req_type == REQ_TRANSLATE)) begin
      md_start = built && (key != '0) && (chosen_size != '0);
    end
  end

  // Table memory access by state.
  always_comb begin
    tm_we   = 1'b0;
    tm_addr = {~live_bank, md_rem};
    tm_wk   = k_r;
    tm_wv   = v_r;
    unique case (state)
      S_SWEEP: begin
        tm_we   = 1'b1;
        tm_addr = {~live_bank, sweep_idx};
        tm_wk   = '0;
      end
      S_B_MOD: begin
        tm_we = md_done && undo;
        tm_wk = '0;
      end
      S_B_CHECK: begin
        tm_addr = {~live_bank, slot_r};
        tm_we   = slot_free;
      end
      S_T_MOD: begin
        tm_addr = {live_bank, md_rem};
      end
      default: begin
        tm_we = 1'b0;
      end
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (pm_we) begin
      pk_mem[pm_waddr] <= key;
      pv_mem[pm_waddr] <= value;
    end
    pk_q <= pk_mem[pm_raddr];
    pv_q <= pv_mem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      tk_mem[tm_addr] <= tm_wk;
      tv_mem[tm_addr] <= tm_wv;
    end
    tk_q <= tk_mem[tm_addr];
    tv_q <= tv_mem[tm_addr];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      search_limit <= 8'd32;
      compress     <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_SEARCH_LIMIT: search_limit <= wr_data;
        CFG_COMPRESS:     compress     <= wr_data[0];
        default:          search_limit <= search_limit;
      endcase
    end
  end

  // Main sequencer and output register.
  always_ff @(posedge clk) begin
    logic [31:0] sz32;
    sz32 = 32'(chosen_size);
    if (rst) begin
      state       <= S_SWEEP;
      sweep_idx   <= '0;
      post_build  <= 1'b0;
      live_bank   <= 1'b1;
      pair_count  <= '0;
      chosen_size <= '0;
      chosen_mult <= '0;
      built       <= 1'b0;
      undo        <= 1'b0;
      j           <= '0;
      fail_j      <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // The output register empties when its beat is taken, unless refilled below.
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == '1) begin
            state <= post_build ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            mem_r <= 1'b0;
            k_r   <= key;
            unique case (req_type)
              REQ_LOAD: begin
                ch_r  <= '0;
                state <= S_DONE;
                if ((key != '0) && (pair_count >= PW'(MAX_PAIRS))) begin
                  st_r <= ST_FULL;
                end else begin
                  st_r <= ST_OK;
                end
                if ((key != '0) && (pair_count < PW'(MAX_PAIRS))) begin
                  pair_count <= pair_count + 1'b1;
                end
              end
              REQ_BUILD: begin
                ch_r <= '0;
                if ((search_limit == '0) || (32'(pair_count) >= 32'(MAX_TABLE))) begin
                  st_r  <= ST_NOHASH;
                  state <= S_DONE;
                end else begin
                  st_r   <= ST_OK;
                  size_r <= (pair_count == '0) ? SW'(1) : SW'(pair_count);
                  mult_r <= MULT_BITS'(1);
                  j      <= '0;
                  undo   <= 1'b0;
                  state  <= S_B_LOOP;
                end
              end
              REQ_TRANSLATE: begin
                st_r <= ST_OK;
                ch_r <= key;
                if (md_start) begin
                  state <= S_T_MOD;
                end else begin
                  state <= S_DONE;
                end
              end
              REQ_CLEAR: begin
                st_r       <= ST_OK;
                ch_r       <= '0;
                pair_count <= '0;
                state      <= S_DONE;
              end
              default: begin
                st_r  <= ST_OK;
                ch_r  <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_T_MOD: begin
          if (md_done) begin
            state <= S_T_CMP;
          end
        end
        S_T_CMP: begin
          if (tk_q == k_r) begin
            ch_r  <= tv_q;
            mem_r <= 1'b1;
          end
          state <= S_DONE;
        end
        S_B_LOOP: begin
          if (!undo && (j == pair_count)) begin
            // Whole trial placed without collision: the scratch bank goes live.
            chosen_size <= size_r;
            chosen_mult <= mult_r;
            built       <= 1'b1;
            live_bank   <= ~live_bank;
            sweep_idx   <= '0;
            post_build  <= 1'b1;
            state       <= S_SWEEP;
          end else if (undo && (j == fail_j)) begin
            state <= S_B_NEXT;
          end else begin
            state <= S_B_PREAD;
          end
        end
        S_B_PREAD: begin
          k_r <= pk_q;
          v_r <= pv_q;
          if (skip_pair) begin
            j     <= j + 1'b1;
            state <= S_B_LOOP;
          end else begin
            state <= S_B_MOD;
          end
        end
        S_B_MOD: begin
          if (md_done) begin
            slot_r <= md_rem;
            if (undo) begin
              j     <= j + 1'b1;
              state <= S_B_LOOP;
            end else begin
              state <= S_B_CHECK;
            end
          end
        end
        S_B_CHECK: begin
          if (slot_free) begin
            j <= j + 1'b1;
          end else begin
            // Collision: walk back the pairs already placed.
            fail_j <= j;
            undo   <= 1'b1;
            j      <= '0;
          end
          state <= S_B_LOOP;
        end
        S_B_NEXT: begin
          undo <= 1'b0;
          j    <= '0;
          if (mult_r < search_limit) begin
            mult_r <= mult_r + 1'b1;
            state  <= S_B_LOOP;
          end else if (32'(size_r) >= 32'(MAX_TABLE - 1)) begin
            st_r  <= ST_NOHASH;
            state <= S_DONE;
          end else begin
            size_r <= size_r + 1'b1;
            mult_r <= MULT_BITS'(1);
            state  <= S_B_LOOP;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid   <= 1'b1;
            status      <= st_r;
            result_char <= ch_r;
            member      <= mem_r;
            table_size  <= sz32[7:0];
            multiplier  <= chosen_mult;
            post_build  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A hit is only ever reported with an ok status.
  a_member_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && member) |-> (status == ST_OK))
    else $error("member set on a non-ok result");

  // A built table always has a usable size and multiplier.
  a_built_valid: assert property (@(posedge clk) disable iff (rst)
    built |-> ((chosen_size != '0) && (chosen_mult != '0)))
    else $error("built table with zero size or multiplier");

  // The remainder unit only finishes while the sequencer waits for it.
  a_mod_owner: assert property (@(posedge clk) disable iff (rst)
    md_done |-> ((state == S_T_MOD) || (state == S_B_MOD)))
    else $error("remainder finished outside a waiting state");

  // The walk back never runs past the pair that collided.
  a_undo_bound: assert property (@(posedge clk) disable iff (rst)
    undo |-> (j <= fail_j))
    else $error("undo walk past the colliding pair");

endmodule

@@ hdl/phct_mod.sv @@
// Multi-cycle remainder unit: four restoring steps per clock.
module phct_mod #(
  parameter int P  = 24,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [P-1:0]  dividend,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [SW-1:0] rem
);

  localparam int DIG  = 4;
  localparam int NCYC = (P + DIG - 1) / DIG;
  localparam int PP   = NCYC * DIG;
  localparam int CW   = $clog2(NCYC + 1);

  logic [PP-1:0] num;
  logic [SW-1:0] div_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [SW-1:0] rem_next;

  // Four dependent compare-and-subtract steps on the partial remainder.
  always_comb begin
    logic [SW:0] t;
    rem_next = rem;
    for (int i = 0; i < DIG; i++) begin
      t = {rem_next, num[PP-1-i]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      rem_next = t[SW-1:0];
    end
  end

  // Sequencing of the digit steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        num   <= PP'(dividend);
        div_r <= divisor;
        rem   <= '0;
        cnt   <= CW'(NCYC);
        busy  <= 1'b1;
        done  <= 1'b0;
      end else if (busy) begin
        rem  <= rem_next;
        num  <= num << DIG;
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule
